>>> design/lssr_pkg.sv
// shared types and constants for the least-squares scale ratio unit
// no dependencies

package lssr_pkg;

  localparam int unsigned IN_W         = 16;
  localparam int unsigned DOT_TERM_W   = 32;
  localparam int unsigned SQ_TERM_W    = 33;
  localparam int unsigned SUM_W        = 64;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned SCALE_W      = 32;
  localparam int unsigned DIV_STEPS    = SUM_W + FRAC_W;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned ROUND_SHIFT  = 14;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_DIV,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    logic signed [DOT_TERM_W-1:0] dot_term;
    logic [SQ_TERM_W-1:0]         sq_term;
    logic                         last;
  } lssr_term_t;

endpackage

>>> design/lssr_front.sv
// front end: accepts element pairs and forms the product terms in two stages
// depends on lssr_pkg

module lssr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        weighted_mode_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lssr_pkg::IN_W-1:0]   a_value_i,
  input  logic [lssr_pkg::IN_W-1:0]   t_value_i,
  input  logic [lssr_pkg::IN_W-1:0]   w2_value_i,
  input  logic                        last_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output lssr_pkg::lssr_term_t        push_data_o
);
  import lssr_pkg::*;

  localparam int unsigned A2_W   = 2 * IN_W - 1;
  localparam int unsigned PROD_W = A2_W + IN_W + 1;

  logic                         s1_valid_q;
  logic signed [DOT_TERM_W-1:0] s1_at_q;
  logic [A2_W-1:0]              s1_aa_q;
  logic [IN_W-1:0]              s1_w2_q;
  logic                         s1_last_q;
  logic                         s2_valid_q;
  lssr_term_t                   s2_term_q;

  logic signed [2*IN_W-1:0] at_full;
  logic signed [2*IN_W-1:0] aa_full;
  logic [PROD_W-1:0]        wprod;
  logic [SQ_TERM_W-1:0]     sq_term;
  logic                     s1_adv;
  logic                     s2_adv;

  assign at_full = $signed(a_value_i) * $signed(t_value_i);
  assign aa_full = $signed(a_value_i) * $signed(a_value_i);
  assign wprod   = PROD_W'(s1_aa_q) * PROD_W'(s1_w2_q)
                 + PROD_W'(1 << (ROUND_SHIFT - 1));
  assign sq_term = weighted_mode_i ? wprod[ROUND_SHIFT +: SQ_TERM_W]
                                   : SQ_TERM_W'(s1_aa_q);

  assign s2_adv       = !s2_valid_q || push_ready_i;
  assign s1_adv       = !s1_valid_q || s2_adv;
  assign in_ready_o   = s1_adv;
  assign push_valid_o = s2_valid_q;
  assign push_data_o  = s2_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_at_q   <= DOT_TERM_W'(at_full);
      s1_aa_q   <= aa_full[A2_W-1:0];
      s1_w2_q   <= w2_value_i;
      s1_last_q <= last_i;
    end
    if (s2_adv && s1_valid_q) begin
      s2_term_q.dot_term <= s1_at_q;
      s2_term_q.sq_term  <= sq_term;
      s2_term_q.last     <= s1_last_q;
    end
  end

endmodule

>>> design/lssr_queue.sv
// short queue of product terms between front and back
// depends on lssr_pkg

module lssr_queue #(
  parameter int unsigned DEPTH = lssr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  lssr_pkg::lssr_term_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output lssr_pkg::lssr_term_t pop_data_o
);
  import lssr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lssr_term_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> design/lssr_back.sv
// back end: accumulates the sums and runs the restoring divider per matrix
// depends on lssr_pkg

module lssr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  lssr_pkg::lssr_term_t          pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lssr_pkg::SCALE_W-1:0]  scale_value_o,
  output logic                          zero_den_o,
  output logic                          saturated_o
);
  import lssr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned QUO_W = SCALE_W + 1;

  back_state_e state_q;
  back_state_e state_d;

  logic [SUM_W-1:0]   dot_q;
  logic [SUM_W-1:0]   sq_q;
  logic [SUM_W-1:0]   dvd_q;
  logic [SUM_W-1:0]   rem_q;
  logic [SUM_W-1:0]   den_q;
  logic [QUO_W-1:0]   quo_q;
  logic               ovf_q;
  logic               neg_q;
  logic               zden_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic [SCALE_W-1:0] out_scale_q;
  logic               out_zden_q;
  logic               out_sat_q;

  logic [SUM_W-1:0]   dot_next;
  logic [SUM_W-1:0]   sq_next;
  logic [SUM_W:0]     trial;
  logic [SUM_W:0]     diff;
  logic               ge;
  logic [QUO_W-1:0]   limit;
  logic               sat;
  logic [SCALE_W-1:0] mag;
  logic [SCALE_W-1:0] scale;
  logic               do_pop;
  logic               load_out;
  logic               div_done;

  assign dot_next = dot_q + SUM_W'(pop_data_i.dot_term);
  assign sq_next  = sq_q + SUM_W'(pop_data_i.sq_term);
  assign trial    = {rem_q, dvd_q[SUM_W-1]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = trial >= {1'b0, den_q};
  assign div_done = cnt_q == CNT_W'(DIV_STEPS - 1);

  assign limit = neg_q ? QUO_W'(33'h080000000) : QUO_W'(33'h07FFFFFFF);
  assign sat   = !zden_q && (ovf_q || (quo_q > limit));
  assign mag   = sat ? limit[SCALE_W-1:0] : quo_q[SCALE_W-1:0];
  assign scale = zden_q ? '0 : (neg_q ? (~mag + 1'b1) : mag);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_ACC: begin
        if (pop_valid_i && pop_data_i.last) begin
          state_d = (sq_next == '0) ? BK_FIN : BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) state_d = BK_FIN;
      end
      BK_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = BK_ACC;
      end
      default: state_d = BK_ACC;
    endcase
  end

  // state outputs
  always_comb begin
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      BK_ACC:  pop_ready_o = 1'b1;
      BK_DIV:  ;
      BK_FIN:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign do_pop = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_ACC;
      dot_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_pop) begin
        dot_q <= pop_data_i.last ? '0 : dot_next;
        sq_q  <= pop_data_i.last ? '0 : sq_next;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop && pop_data_i.last) begin
      den_q  <= sq_next;
      neg_q  <= dot_next[SUM_W-1];
      dvd_q  <= dot_next[SUM_W-1] ? (~dot_next + 1'b1) : dot_next;
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      zden_q <= sq_next == '0;
      cnt_q  <= '0;
    end else if (state_q == BK_DIV) begin
      rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
      ovf_q <= ovf_q | quo_q[QUO_W-1];
      cnt_q <= cnt_q + 1'b1;
    end
    if (load_out) begin
      out_scale_q <= scale;
      out_zden_q  <= zden_q;
      out_sat_q   <= sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scale_value_o = out_scale_q;
  assign zero_den_o    = out_zden_q;
  assign saturated_o   = out_sat_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> cnt_q <= CNT_W'(DIV_STEPS - 1))
    else $error("divider step count out of range");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> den_q != '0)
    else $error("divider running on a zero denominator");

  a_last_leaves_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && pop_data_i.last |=> state_q != BK_ACC)
    else $error("last element did not start the ratio");

  a_zden_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_zden_q |-> out_scale_q == '0 && !out_sat_q)
    else $error("zero denominator result not cleared");
`endif

endmodule

>>> design/least_squares_scale_ratio_unit.sv
// Least-squares scale ratio unit: streams element pairs, accumulates the dot
// and square sums and reports sum_at / sum_a2 as saturated Q16.16 per matrix.
// The front forms the products in a two-stage pipeline and accepts one element
// per cycle while the four-entry queue has room; the back adds one term per
// cycle while it accumulates. After the last element of a matrix the back runs
// a restoring divider, one quotient bit per cycle (skipped when the square sum
// is zero), then loads the result into the output register once the output is
// free; elements keep entering the queue meanwhile.
// depends on lssr_pkg, lssr_front, lssr_queue, lssr_back

module least_squares_scale_ratio_unit #(
  parameter int unsigned QUEUE_DEPTH = lssr_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // weighted_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // a_value, t_value, w2_value
  input  logic        s_axis_tlast,   // last_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // scale_value
  output logic [1:0]  m_axis_tuser    // zero_denominator, saturated
);
  import lssr_pkg::*;

  logic       mode_q;
  logic       push_valid;
  logic       push_ready;
  lssr_term_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  lssr_term_t pop_data;
  logic       zden;
  logic       sat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  lssr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .weighted_mode_i (mode_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .a_value_i       (s_axis_tdata[15:0]),
    .t_value_i       (s_axis_tdata[31:16]),
    .w2_value_i      (s_axis_tdata[47:32]),
    .last_i          (s_axis_tlast),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_data_o     (push_data)
  );

  lssr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lssr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .scale_value_o (m_axis_tdata),
    .zero_den_o    (zden),
    .saturated_o   (sat)
  );

  assign m_axis_tuser = {sat, zden};

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for least_squares_scale_ratio_unit: directed and random matrices,
// scale ratios predicted in a scoreboard class and checked per result
// depends on the unit and its package

module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 192;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // a_value, t_value, w2_value
  logic        s_axis_tlast;   // last_element
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // scale_value
  logic [1:0]  m_axis_tuser;   // zero_denominator, saturated

  int unsigned cycle_count;
  bit          held_off;

  typedef struct {
    logic [31:0] scale;
    logic        zden;
    logic        sat;
  } scale_result_t;

  class scale_scoreboard;
    logic [63:0]   dot_acc = '0;
    logic [63:0]   sq_acc = '0;
    bit            weighted;
    scale_result_t pending_scales[$];
    int            errors;
    int            results_seen;

    function void set_mode(bit m);
      weighted = m;
    endfunction

    function int pending();
      return pending_scales.size();
    endfunction

    function logic [31:0] ratio_q16(input logic [63:0] num, input logic [63:0] den,
                                    output logic sat);
      logic        neg;
      logic [63:0] mag, q, r, res, limit;
      logic [64:0] r2;
      logic [15:0] frac;
      int          i;
      neg   = num[63];
      mag   = neg ? -num : num;
      q     = mag / den;
      r     = mag % den;
      limit = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      sat   = 1'b0;
      if (q > 64'h8000) begin
        sat = 1'b1;
        return neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      frac = '0;
      for (i = 0; i < 16; i++) begin
        r2   = {r, 1'b0};
        frac = frac << 1;
        if (r2 >= {1'b0, den}) begin
          r2      = r2 - {1'b0, den};
          frac[0] = 1'b1;
        end
        r = r2[63:0];
      end
      res = (q << 16) | {48'd0, frac};
      if (res > limit) begin
        sat = 1'b1;
        res = limit;
      end
      if (neg) res = -res;
      return res[31:0];
    endfunction

    function void note_element(logic [15:0] a, logic [15:0] t, logic [15:0] w2, bit last);
      longint          ap, tp;
      longint unsigned a2, w;
      scale_result_t   r;
      logic            s;
      ap = longint'($signed(a));
      tp = longint'($signed(t));
      a2 = ap * ap;
      w  = longint'(w2);
      dot_acc = dot_acc + ap * tp;
      if (weighted) sq_acc = sq_acc + ((a2 * w + 64'h2000) >> 14);
      else sq_acc = sq_acc + a2;
      if (!last) return;
      if (sq_acc == 0) begin
        r.scale = '0;
        r.zden  = 1'b1;
        r.sat   = 1'b0;
      end else begin
        r.scale = ratio_q16(dot_acc, sq_acc, s);
        r.zden  = 1'b0;
        r.sat   = s;
      end
      pending_scales.push_back(r);
      dot_acc = '0;
      sq_acc  = '0;
    endfunction

    function void check_result(logic [31:0] scale, logic zden, logic sat);
      scale_result_t e;
      results_seen++;
      if (pending_scales.size() == 0) begin
        $error("result with no request pending: scale_value %h", scale);
        errors++;
        return;
      end
      e = pending_scales.pop_front();
      if (scale !== e.scale) begin
        $error("scale_value: expected %h, actual %h", e.scale, scale);
        errors++;
      end
      if (zden !== e.zden) begin
        $error("zero_denominator: expected %0b, actual %0b", e.zden, zden);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated: expected %0b, actual %0b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  scale_scoreboard sb = new;

  least_squares_scale_ratio_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle with a chance of 15 in 100 per call, never inside the quiet window
  function automatic bit take_break();
    if (cycle_count >= 5000 && cycle_count < 9000) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
  end

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && sb.results_seen >= 40) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      m_axis_tready <= !take_break();
    end
  end

  task automatic wait_for_drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    wait_for_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    sb.set_mode(m);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_elem(input logic [15:0] a, input logic [15:0] t,
                           input logic [15:0] w2, input bit last);
    while (take_break()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w2, t, a};
    s_axis_tlast  <= last;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sb.note_element(a, t, w2, last);
  endtask

  task automatic send_matrix(output int len);
    int          flavor, k;
    logic [15:0] a, t, w2;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    flavor = $urandom_range(0, 9);
    for (k = 0; k < len; k++) begin
      a  = 16'($urandom());
      t  = 16'($urandom());
      w2 = 16'($urandom());
      case (flavor)
        0: a = '0;
        1: begin
          // in weighted mode, tiny image values and weights push the ratio past the range
          a  = 16'($urandom_range(1, 300));
          if ($urandom_range(0, 1)) a = -a;
          w2 = 16'($urandom_range(0, 3));
        end
        2: begin
          a  = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          t  = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          w2 = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end
        3: w2 = '0;
        default: ;
      endcase
      send_elem(a, t, w2, k == len - 1);
    end
  endtask

  initial begin : stimulus
    int n, count, phase;
    bit modes[6];
    modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    send_elem(16'h0000, 16'h0000, 16'h1234, 1'b1);
    send_elem(16'h0001, 16'h8000, 16'h0000, 1'b1);
    send_elem(16'h0001, 16'h7fff, 16'hffff, 1'b1);
    send_elem(16'h8000, 16'h8000, 16'h0000, 1'b1);
    send_elem(16'h7fff, 16'h8000, 16'h0000, 1'b1);
    send_elem(16'h8000, 16'h7fff, 16'h0000, 1'b0);
    send_elem(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_elem(16'h0003, 16'hfffb, 16'h0000, 1'b1);
    send_elem(16'hffff, 16'h0001, 16'h0000, 1'b1);
    s_axis_tvalid <= 1'b0;

    write_mode(1'b1);
    send_elem(16'h0080, 16'h7fff, 16'h0001, 1'b1);
    send_elem(16'h0080, 16'h8000, 16'h0001, 1'b1);
    send_elem(16'h0080, 16'h0100, 16'h0001, 1'b1);
    send_elem(16'h7fff, 16'h7fff, 16'h0000, 1'b1);
    send_elem(16'h0040, 16'h7fff, 16'h0001, 1'b1);
    send_elem(16'h8000, 16'h8000, 16'hffff, 1'b1);
    send_elem(16'h0064, 16'hff38, 16'h4000, 1'b0);
    send_elem(16'hfff9, 16'h0009, 16'h9c40, 1'b1);
    s_axis_tvalid <= 1'b0;

    for (phase = 0; phase < 6; phase++) begin
      write_mode(modes[phase]);
      count = 0;
      while (count < PHASE_ITEMS) begin
        send_matrix(n);
        count += n;
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_for_drain();
    if (sb.pending() != 0) begin
      $error("%0d scale results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> least_squares_scale_ratio_unit.f
design/lssr_pkg.sv
design/lssr_front.sv
design/lssr_queue.sv
design/lssr_back.sv
design/least_squares_scale_ratio_unit.sv
verif/tb_top.sv
